// File: rtl/fpdc_pkg.sv
// Shared types, constants and divider tables for the fractional PLL divider calculator.
`timescale 1ns / 1ps
`default_nettype none

package fpdc_pkg;

	// Configuration register indexes
	localparam int unsigned REG_VCO_MIN = 0;
	localparam int unsigned REG_REF     = 1;

	// Divider table
	localparam int unsigned TABLE_ENTRIES  = 24;
	localparam int unsigned DIV_TABLE_SIZE = 24;
	localparam int unsigned N_USED = (DIV_TABLE_SIZE > TABLE_ENTRIES) ? TABLE_ENTRIES :
		((DIV_TABLE_SIZE < 1) ? 1 : DIV_TABLE_SIZE);

	localparam logic [6:0] DIV_TAB [TABLE_ENTRIES] = '{
		7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd8, 7'd9, 7'd10,
		7'd12, 7'd14, 7'd15, 7'd16, 7'd20, 7'd21, 7'd24,
		7'd25, 7'd30, 7'd36, 7'd42, 7'd49, 7'd56, 7'd64
	};
	// Post divider codes (divider value minus one)
	localparam logic [2:0] PD1_CODE [TABLE_ENTRIES] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd3,
		3'd6, 3'd4, 3'd3, 3'd4, 3'd6, 3'd5, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7, 3'd7
	};
	localparam logic [2:0] PD2_CODE [TABLE_ENTRIES] = '{
		3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd1, 3'd2,
		3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd7
	};
	localparam logic [6:0] TAB_LAST = DIV_TAB[N_USED-1];

	// VCO ceiling used to pick K
	localparam logic [28:0] VCO_CEIL = 29'd300000000;

	localparam logic [1:0] REF_DIV_OK  = 2'd2;
	localparam logic [1:0] EXTRA_DIV_1 = 2'd1;
	localparam logic [1:0] EXTRA_DIV_2 = 2'd2;

	// Per-item side information carried down the pipeline
	typedef struct packed {
		logic [30:0] eclk;
		logic [1:0]  extra_div;
		logic [2:0]  pd1;
		logic [2:0]  pd2;
		logic        found;
		logic        zerr;
	} side_t;

	// Side information through the K divider
	typedef struct packed {
		side_t       side;
		logic [62:0] vco;
		logic        big;
	} kpay_t;

endpackage

`default_nettype wire

// File: rtl/fpdc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with pass-along payload.
`timescale 1ns / 1ps
`default_nettype none

module fpdc_div #(
	parameter int NUM_W = 33,
	parameter int DEN_W = 31,
	parameter int PW    = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	input  wire logic [PW-1:0]    pay_in,
	output logic                  out_valid,
	output logic [NUM_W-1:0]      quo,
	output logic [PW-1:0]         pay_out
);

	logic             vld_s [NUM_W+1];
	logic [NUM_W-1:0] nq_s  [NUM_W+1];
	logic [DEN_W-1:0] dn_s  [NUM_W];
	logic [DEN_W-1:0] rm_s  [NUM_W];
	logic [PW-1:0]    pay_s [NUM_W+1];

	assign vld_s[0] = in_valid;
	assign nq_s[0]  = num;
	assign dn_s[0]  = den;
	assign rm_s[0]  = '0;
	assign pay_s[0] = pay_in;

	for (genvar i = 0; i < NUM_W; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		// Shift in the next numerator bit and try a subtract
		assign trial = {rm_s[i], nq_s[i][NUM_W-1]};
		assign ge    = trial >= {1'b0, dn_s[i]};
		assign diff  = trial - {1'b0, dn_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[i+1]  <= {nq_s[i][NUM_W-2:0], ge};
				pay_s[i+1] <= pay_s[i];
			end
		end

		if (i < NUM_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rm_s[i+1] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
					dn_s[i+1] <= dn_s[i];
				end
			end
		end
	end

	assign out_valid = vld_s[NUM_W];
	assign quo       = nq_s[NUM_W];
	assign pay_out   = pay_s[NUM_W];

endmodule

`default_nettype wire

// File: rtl/fpdc_regs.sv
// APB configuration registers: minimum VCO frequency and reference frequency.
`timescale 1ns / 1ps
`default_nettype none

module fpdc_regs
	import fpdc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output logic [31:0]      vco_min_q,
	output logic [31:0]      ref_q
);

	logic [0:0] idx;

	assign idx    = paddr[2:2];
	assign pready = 1'b1;

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_min_q <= 32'd630000000;
			ref_q     <= 32'd38400000;
		end else if (psel && penable && pwrite) begin
			case (idx)
				1'(REG_VCO_MIN): vco_min_q <= pwdata;
				1'(REG_REF):     ref_q     <= pwdata;
				default:         ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			1'(REG_VCO_MIN): prdata = vco_min_q;
			1'(REG_REF):     prdata = ref_q;
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fractional_pll_divider_calc.sv
// Top level of the fractional-N PLL divider calculator: pipeline, output skid and checks.
`timescale 1ns / 1ps
`default_nettype none

// Takes one requested pixel clock per cycle and returns the fractional-N PLL
// settings for it through 158 register stages: three restoring dividers
// (33, 30 and 87 stages, one quotient bit each) plus seven stages for capture,
// doubling, ceiling numerator, table lookup, K setup and the two multiplies,
// plus the output register. A new item enters every cycle; when the output is
// held, one result parks in a skid register and input stalls until it drains.
// Writes to the two APB registers must be done while the pipeline is empty.

module fractional_pll_divider_calc
	import fpdc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Input stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [31:0]  s_axis_tdata,   // [29:0] pix_hz
	// Result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata,   // [30:0] effective_clock, [32:31] extra_div,
	                                          // [35:33] postdiv1_code, [38:36] postdiv2_code,
	                                          // [39] divider_found, [41:40] ref_div,
	                                          // [73:42] fb_div, [97:74] frac_div,
	                                          // [98] calc_error
	// Configuration
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0] vco_min_q;
	logic [31:0] ref_q;
	logic        en;

	fpdc_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.vco_min_q (vco_min_q),
		.ref_q     (ref_q)
	);

	// ---------------------------------------------------------------- s1: capture
	logic        v_s1;
	logic [29:0] clk_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) clk_s1 <= s_axis_tdata[29:0];
	end

	// ---------------------------------------------------------------- s2: doubling
	logic        v_s2;
	logic [30:0] eclk_s2;
	logic [1:0]  pdiv_s2;
	logic [36:0] span;

	assign span = 37'(clk_s1) * 37'(TAB_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			if (span < {5'd0, vco_min_q}) begin
				eclk_s2 <= {clk_s1, 1'b0};
				pdiv_s2 <= EXTRA_DIV_2;
			end else begin
				eclk_s2 <= {1'b0, clk_s1};
				pdiv_s2 <= EXTRA_DIV_1;
			end
		end
	end

	// ---------------------------------------------------------------- s3: ceiling numerator
	logic        v_s3;
	side_t       side_s3;
	side_t       side_n3;
	logic [32:0] num1_s3;

	always_comb begin
		side_n3           = '0;
		side_n3.eclk      = eclk_s2;
		side_n3.extra_div = pdiv_s2;
		side_n3.zerr      = (eclk_s2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			num1_s3 <= {1'b0, vco_min_q} + {2'b0, eclk_s2} - 33'd1;
			side_s3 <= side_n3;
		end
	end

	// ---------------------------------------------------------------- needed divider
	logic        d1_v;
	logic [32:0] need;
	logic [$bits(side_t)-1:0] d1_pay;
	side_t       side_d1;

	fpdc_div #(.NUM_W(33), .DEN_W(31), .PW($bits(side_t))) u_div_need (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.num       (num1_s3),
		.den       (side_s3.eclk),
		.pay_in    (side_s3),
		.out_valid (d1_v),
		.quo       (need),
		.pay_out   (d1_pay)
	);
	assign side_d1 = side_t'(d1_pay);

	// ---------------------------------------------------------------- s4: table lookup
	logic        v_s4;
	side_t       side_s4;
	side_t       side_n4;
	logic [31:0] divider_s4;
	logic        hit;
	logic [6:0]  hit_div;
	logic [2:0]  hit_pd1;
	logic [2:0]  hit_pd2;

	// Lowest matching entry wins
	always_comb begin
		hit     = 1'b0;
		hit_div = '0;
		hit_pd1 = '0;
		hit_pd2 = '0;
		for (int i = N_USED - 1; i >= 0; i--) begin
			if ({26'd0, DIV_TAB[i]} >= need) begin
				hit     = 1'b1;
				hit_div = DIV_TAB[i];
				hit_pd1 = PD1_CODE[i];
				hit_pd2 = PD2_CODE[i];
			end
		end
	end

	always_comb begin
		side_n4       = side_d1;
		side_n4.found = hit;
		side_n4.pd1   = hit_pd1;
		side_n4.pd2   = hit_pd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= d1_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s4    <= side_n4;
			divider_s4 <= hit ? {25'd0, hit_div} : need[31:0];
		end
	end

	// ---------------------------------------------------------------- s5: VCO multiply
	logic        v_s5;
	side_t       side_s5;
	logic [62:0] vco_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_s4;
			vco_s5  <= divider_s4 * side_s4.eclk;
		end
	end

	// ---------------------------------------------------------------- s6: K setup
	logic        v_s6;
	kpay_t       kp_s6;
	kpay_t       kp_n6;
	logic [29:0] num2_s6;
	logic [28:0] den2_s6;
	logic        vco_zero;

	assign vco_zero = (vco_s5 == '0);

	// Zero clock or zero VCO drops the table result
	always_comb begin
		kp_n6.side = side_s5;
		kp_n6.vco  = vco_s5;
		kp_n6.big  = (vco_s5 >= {34'd0, VCO_CEIL});
		if (side_s5.zerr || vco_zero) begin
			kp_n6.side.zerr  = 1'b1;
			kp_n6.side.found = 1'b0;
			kp_n6.side.pd1   = '0;
			kp_n6.side.pd2   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			kp_s6   <= kp_n6;
			num2_s6 <= {1'b0, VCO_CEIL} + {1'b0, vco_s5[28:0]} - 30'd1;
			den2_s6 <= vco_s5[28:0];
		end
	end

	// ---------------------------------------------------------------- K divider
	logic        d2_v;
	logic [29:0] kq;
	logic [$bits(kpay_t)-1:0] d2_pay;
	kpay_t       kp_d2;

	fpdc_div #(.NUM_W(30), .DEN_W(29), .PW($bits(kpay_t))) u_div_k (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.num       (num2_s6),
		.den       (den2_s6),
		.pay_in    (kp_s6),
		.out_valid (d2_v),
		.quo       (kq),
		.pay_out   (d2_pay)
	);
	assign kp_d2 = kpay_t'(d2_pay);

	// ---------------------------------------------------------------- s7: VCO*K
	logic        v_s7;
	side_t       side_s7;
	logic [62:0] prod_s7;
	logic [57:0] small_prod;

	assign small_prod = kp_d2.vco[28:0] * kq[28:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= d2_v;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			side_s7 <= kp_d2.side;
			prod_s7 <= kp_d2.big ? kp_d2.vco : {5'd0, small_prod};
		end
	end

	// ---------------------------------------------------------------- feedback divider
	logic        d3_v;
	logic [86:0] fq;
	logic [$bits(side_t)-1:0] d3_pay;
	side_t       side_d3;

	fpdc_div #(.NUM_W(87), .DEN_W(32), .PW($bits(side_t))) u_div_fb (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.num       ({prod_s7, 24'd0}),
		.den       (ref_q),
		.pay_in    (side_s7),
		.out_valid (d3_v),
		.quo       (fq),
		.pay_out   (d3_pay)
	);
	assign side_d3 = side_t'(d3_pay);

	// ---------------------------------------------------------------- result assembly
	logic         err;
	logic [31:0]  fb_sat;
	logic [103:0] res;

	assign err    = side_d3.zerr || (ref_q == '0);
	assign fb_sat = (fq[86:56] != '0) ? 32'hFFFF_FFFF : fq[55:24];

	always_comb begin
		res          = '0;
		res[30:0]    = side_d3.eclk;
		res[32:31]   = side_d3.extra_div;
		res[35:33]   = side_d3.pd1;
		res[38:36]   = side_d3.pd2;
		res[39]      = side_d3.found;
		res[41:40]   = err ? 2'd0 : REF_DIV_OK;
		res[73:42]   = err ? 32'd0 : fb_sat;
		res[97:74]   = err ? 24'd0 : fq[23:0];
		res[98]      = err;
	end

	// ---------------------------------------------------------------- output register and skid
	logic         out_v_q;
	logic [103:0] out_q;
	logic         skid_v_q;
	logic [103:0] skid_q;

	assign en            = !skid_v_q;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (en) begin
			if (d3_v) begin
				if (!out_v_q || m_axis_tready) begin
					out_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end else if (m_axis_tready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d3_v) begin
				if (!out_v_q || m_axis_tready) begin
					out_q <= res;
				end else begin
					skid_q <= res;
				end
			end
		end else if (m_axis_tready) begin
			out_q <= skid_q;
		end
	end

	// ---------------------------------------------------------------- checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while the output register is empty");

	a_held_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("held result dropped");

	a_ok_refdiv: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[98]) |-> (m_axis_tdata[41:40] == REF_DIV_OK))
		else $error("ref_div wrong on a completed calculation");

endmodule

`default_nettype wire

// File: tb/fractional_pll_divider_calc_tb.sv
// Testbench for the fractional-N PLL divider calculator: directed and random clocks vs a scoreboard.
`timescale 1ns / 1ps

import fpdc_pkg::*;

typedef struct {
	logic [30:0] eclk;
	logic [1:0]  extra_div;
	logic [2:0]  pd1;
	logic [2:0]  pd2;
	logic        found;
	logic [1:0]  ref_div;
	logic [31:0] fb_div;
	logic [23:0] frac_div;
	logic        err;
} pll_set_t;

class pll_scoreboard;
	logic [31:0] vco_min;
	logic [31:0] ref_hz;
	pll_set_t pending[$];
	int errors;

	function new();
		vco_min = 32'd630000000;
		ref_hz = 32'd38400000;
		errors = 0;
	endfunction

	// Work out the PLL settings for one requested clock
	function pll_set_t calc_settings(logic [29:0] pix);
		pll_set_t s;
		logic [63:0] c, need, dv, vco, k, prod, q, r, t, rf, vm;
		c = 64'(pix);
		rf = 64'(ref_hz);
		vm = 64'(vco_min);
		s.extra_div = EXTRA_DIV_1;
		s.pd1 = '0; s.pd2 = '0; s.found = 1'b0; s.ref_div = '0;
		s.fb_div = '0; s.frac_div = '0; s.err = 1'b0;
		if (c * 64'(TAB_LAST) < vm) begin
			s.extra_div = EXTRA_DIV_2;
			c = c * 64'd2;
		end
		s.eclk = c[30:0];
		if (c == 64'd0) begin
			s.err = 1'b1;
			return s;
		end
		need = (vm + c - 64'd1) / c;
		dv = need;
		for (int i = 0; i < N_USED; i++) begin
			if (64'(DIV_TAB[i]) >= need) begin
				dv = 64'(DIV_TAB[i]);
				s.pd1 = PD1_CODE[i];
				s.pd2 = PD2_CODE[i];
				s.found = 1'b1;
				break;
			end
		end
		vco = dv * c;
		if (vco == 64'd0) begin
			s.err = 1'b1; s.found = 1'b0; s.pd1 = '0; s.pd2 = '0;
		end else if (rf == 64'd0) begin
			s.err = 1'b1;
		end else begin
			k = (64'd300000000 + vco - 64'd1) / vco;
			prod = vco * k;
			q = prod / rf;
			r = prod % rf;
			s.fb_div = (q > 64'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
			t = (r << 24) / rf;
			s.frac_div = t[23:0];
			s.ref_div = REF_DIV_OK;
		end
		return s;
	endfunction

	function void note_request(logic [29:0] pix);
		pending.push_back(calc_settings(pix));
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic check_result(logic [103:0] d);
		pll_set_t e;
		if (pending.size() == 0) begin
			report("unexpected beat", 0, 0);
			return;
		end
		e = pending.pop_front();
		if (d[30:0] != e.eclk) report("effective_clock", d[30:0], e.eclk);
		if (d[32:31] != e.extra_div) report("extra_div", d[32:31], e.extra_div);
		if (d[35:33] != e.pd1) report("postdiv1_code", d[35:33], e.pd1);
		if (d[38:36] != e.pd2) report("postdiv2_code", d[38:36], e.pd2);
		if (d[39] != e.found) report("divider_found", d[39], e.found);
		if (d[41:40] != e.ref_div) report("ref_div", d[41:40], e.ref_div);
		if (d[73:42] != e.fb_div) report("fb_div", d[73:42], e.fb_div);
		if (d[97:74] != e.frac_div) report("frac_div", d[97:74], e.frac_div);
		if (d[98] != e.err) report("calc_error", d[98], e.err);
	endtask
endclass

module fractional_pll_divider_calc_tb;
	localparam int LATENCY = 160;
	localparam int LIMIT = 400000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic m_axis_tvalid, m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic psel, penable, pwrite, pready;
	logic [2:0] paddr;
	logic [31:0] pwdata, prdata;
	bit stall_on;
	int cycles;

	pll_scoreboard sb;

	fractional_pll_divider_calc DUT (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stall the result side on its own pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else if (stall_on) begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_axis_tready <= 1;
		end
	end

	// Check each result beat
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	task automatic reg_write(logic [2:0] a, logic [31:0] v);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= a; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		if (a == 3'(4 * REG_VCO_MIN)) sb.vco_min = v;
		else sb.ref_hz = v;
	endtask

	task automatic send_clock(logic [29:0] pix);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {2'b00, pix};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_request(pix);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [29:0] rand_clock();
		case ($urandom_range(0, 5))
			0: return 30'($urandom_range(0, 20));
			1: return 30'($urandom_range(1000000, 20000000));
			2: return 30'($urandom_range(20000000, 200000000));
			3: return 30'($urandom_range(0, 1000000000));
			default: return 30'($urandom());
		endcase
	endfunction

	// Send a burst-gapped run of random clocks
	task automatic random_run(int n);
		int left;
		left = n;
		while (left > 0) begin
			for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
				send_clock(rand_clock());
				left--;
			end
			if ($urandom_range(0, 2) == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	logic [29:0] directed[$] = '{30'd0, 30'd1, 30'd2, 30'd9843750, 30'd9843749,
		30'd9843751, 30'd25000000, 30'd148500000, 30'd300000000, 30'd630000000,
		30'd1000000000, 30'h3FFFFFFF, 30'h2AAAAAAA, 30'h15555555, 30'd74250000};

	initial begin
		sb = new();
		arst_n = 0; s_axis_tvalid = 0; s_axis_tdata = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		stall_on = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed clocks at reset settings, no stalls
		foreach (directed[i]) send_clock(directed[i]);
		drain();

		// Zero reference and a tiny one drive error and saturation
		reg_write(3'(4 * REG_REF), 32'd0);
		foreach (directed[i]) send_clock(directed[i]);
		drain();
		reg_write(3'(4 * REG_REF), 32'd1);
		reg_write(3'(4 * REG_VCO_MIN), 32'hFFFFFFFF);
		send_clock(30'd1); send_clock(30'h3FFFFFFF); send_clock(30'd7);
		drain();
		reg_write(3'(4 * REG_VCO_MIN), 32'd1);
		reg_write(3'(4 * REG_REF), 32'hFFFFFFFF);
		send_clock(30'd1); send_clock(30'h3FFFFFFF);
		drain();

		stall_on = 1;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					reg_write(3'(4 * REG_VCO_MIN), 32'd630000000);
					reg_write(3'(4 * REG_REF), 32'd38400000);
				end
				1: begin
					reg_write(3'(4 * REG_VCO_MIN), $urandom());
					reg_write(3'(4 * REG_REF), $urandom_range(1, 100000000));
				end
				2: begin
					reg_write(3'(4 * REG_VCO_MIN), 32'd1);
					reg_write(3'(4 * REG_REF), $urandom_range(1, 1000));
				end
				3: begin
					reg_write(3'(4 * REG_VCO_MIN), $urandom_range(100000000, 2000000000));
					reg_write(3'(4 * REG_REF), $urandom());
				end
				4: reg_write(3'(4 * REG_REF), 32'd27000000);
				default: stall_on = 0;
			endcase
			random_run(320);
			drain();
		end

		if (sb.errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
